// ===== sv/pbm_pkg.sv =====
`default_nettype none

package pbm_pkg;

  localparam int NumBinsDef   = 256;
  localparam int MaxPerBinDef = 64;

  // Port widths fixed by the item format
  localparam int ValueBits = 16;
  localparam int BinBits   = 8;
  localparam int CountBits = 7;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META,
    ST_SHIFT,
    ST_PLACE,
    ST_MED_A,
    ST_MED_B,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

// ===== sv/pbm_ram.sv =====
`default_nettype none

module pbm_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/per_bin_median_engine_core.sv =====
`default_nettype none

// Per-bin median engine. Each bin keeps its samples sorted ascending in its own region of a
// sample RAM; a second RAM holds each bin's count and overflow flag. An add reads the bin's
// count, then walks down from the top of the list, moving one larger entry up per cycle
// (read of the next entry overlaps the write of the current one) until the new sample's
// slot is found and the sample is written there; an add to an empty or full bin ends after
// the count read. A query reads the count and one or two middle entries (none for an empty
// bin); a new transaction is taken while its result waits on the output. Adds to a full bin
// set the bin's overflow flag and are dropped, adds to a bin index at or above NUM_BINS are
// dropped silently. After reset the count RAM is swept to zero, one bin per cycle, with
// in_ready_o low.
module per_bin_median_engine_core #(
  parameter int NUM_BINS    = pbm_pkg::NumBinsDef,
  parameter int MAX_PER_BIN = pbm_pkg::MaxPerBinDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          op_i,
  input  wire logic [pbm_pkg::BinBits-1:0]   bin_i,
  input  wire logic [pbm_pkg::ValueBits-1:0] sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [pbm_pkg::ValueBits-1:0] median_o,
  output logic                               empty_res_o,
  output logic      [pbm_pkg::CountBits-1:0] count_o,
  output logic                               overflowed_o
);

  import pbm_pkg::*;

  localparam int BinW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CntW  = $clog2(MAX_PER_BIN + 1);
  localparam int PosW  = (MAX_PER_BIN > 1) ? $clog2(MAX_PER_BIN) : 1;
  localparam int Depth = NUM_BINS * MAX_PER_BIN;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int MetaW = CntW + 1;

  state_e state_q, state_d;

  logic [BinW-1:0]      clr_q, clr_d;
  logic                 out_valid_q, out_valid_d;

  op_e                  op_q, op_d;
  logic [BinW-1:0]      bin_idx_q, bin_idx_d;
  logic [AddrW-1:0]     base_q, base_d;
  logic [ValueBits-1:0] samp_q, samp_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [ValueBits-1:0] lo_q, lo_d;
  logic [ValueBits-1:0] med_q, med_d;

  logic [ValueBits-1:0] median_q;
  logic                 empty_q;
  logic [CountBits-1:0] count_q;
  logic                 ovfl_out_q;

  logic                 in_acc;
  logic                 bin_ok;
  logic                 out_load;
  logic [BinW-1:0]      in_idx;

  logic                 meta_we;
  logic [BinW-1:0]      meta_waddr, meta_raddr;
  logic [MetaW-1:0]     meta_wdata, meta_rdata;
  logic [CntW-1:0]      meta_cnt;
  logic                 meta_ovf;

  logic                 smp_we;
  logic [AddrW-1:0]     smp_waddr, smp_raddr;
  logic [ValueBits-1:0] smp_wdata, smp_rdata;

  pbm_ram #(
    .Width(MetaW),
    .Depth(NUM_BINS)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(meta_waddr),
    .wdata_i(meta_wdata),
    .raddr_i(meta_raddr),
    .rdata_o(meta_rdata)
  );

  pbm_ram #(
    .Width(ValueBits),
    .Depth(Depth)
  ) u_sample_ram (
    .clk_i  (clk_i),
    .we_i   (smp_we),
    .waddr_i(smp_waddr),
    .wdata_i(smp_wdata),
    .raddr_i(smp_raddr),
    .rdata_o(smp_rdata)
  );

  assign meta_cnt = meta_rdata[MetaW-1:1];
  assign meta_ovf = meta_rdata[0];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign bin_ok     = int'(bin_i) < NUM_BINS;
  assign in_idx     = BinW'(bin_i);
  assign out_load   = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    op_d      = op_q;
    bin_idx_d = bin_idx_q;
    base_d    = base_q;
    samp_d    = samp_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    pos_d     = pos_q;
    lo_d      = lo_q;
    med_d     = med_q;

    meta_we    = 1'b0;
    meta_waddr = bin_idx_q;
    meta_wdata = {cnt_q, ovf_q};
    meta_raddr = in_idx;
    smp_we     = 1'b0;
    smp_waddr  = base_q + AddrW'(pos_q);
    smp_wdata  = samp_q;
    smp_raddr  = base_q;

    case (state_q)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        meta_wdata = '0;
        clr_d      = clr_q + BinW'(1);
        if (clr_q == BinW'(NUM_BINS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          op_d      = op_e'(op_i);
          bin_idx_d = in_idx;
          base_d    = AddrW'(in_idx) * AddrW'(MAX_PER_BIN);
          samp_d    = sample_i;
          cnt_d     = '0;
          ovf_d     = 1'b0;
          med_d     = '0;
          if (bin_ok) begin
            state_d = ST_META;
          end else if (op_e'(op_i) == OP_QUERY) begin
            state_d = ST_RESP;
          end
        end
      end

      ST_META: begin
        cnt_d = meta_cnt;
        ovf_d = meta_ovf;
        if (op_q == OP_ADD) begin
          meta_we = 1'b1;
          if (int'(meta_cnt) >= MAX_PER_BIN) begin
            meta_wdata = {meta_cnt, 1'b1};
            state_d    = ST_IDLE;
          end else begin
            meta_wdata = {meta_cnt + CntW'(1), meta_ovf};
            pos_d      = PosW'(meta_cnt);
            if (meta_cnt == '0) begin
              smp_we    = 1'b1;
              smp_waddr = base_q;
              state_d   = ST_IDLE;
            end else begin
              smp_raddr = base_q + AddrW'(meta_cnt - CntW'(1));
              state_d   = ST_SHIFT;
            end
          end
        end else begin
          if (meta_cnt == '0) begin
            med_d   = '0;
            state_d = ST_RESP;
          end else begin
            // odd count: middle entry; even count: lower of the two middle entries first
            if (meta_cnt[0]) begin
              smp_raddr = base_q + AddrW'(meta_cnt >> 1);
            end else begin
              smp_raddr = base_q + AddrW'((meta_cnt >> 1) - CntW'(1));
            end
            state_d = ST_MED_A;
          end
        end
      end

      ST_SHIFT: begin
        smp_we = 1'b1;
        if (smp_rdata > samp_q) begin
          smp_wdata = smp_rdata;
          pos_d     = pos_q - PosW'(1);
          if (pos_q == PosW'(1)) begin
            state_d = ST_PLACE;
          end else begin
            smp_raddr = base_q + AddrW'(pos_q - PosW'(2));
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_PLACE: begin
        smp_we  = 1'b1;
        state_d = ST_IDLE;
      end

      ST_MED_A: begin
        if (cnt_q[0]) begin
          med_d   = smp_rdata;
          state_d = ST_RESP;
        end else begin
          lo_d      = smp_rdata;
          smp_raddr = base_q + AddrW'(cnt_q >> 1);
          state_d   = ST_MED_B;
        end
      end

      ST_MED_B: begin
        med_d   = ValueBits'(({1'b0, lo_q} + {1'b0, smp_rdata}) >> 1);
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    bin_idx_q <= bin_idx_d;
    base_q    <= base_d;
    samp_q    <= samp_d;
    cnt_q     <= cnt_d;
    ovf_q     <= ovf_d;
    pos_q     <= pos_d;
    lo_q      <= lo_d;
    med_q     <= med_d;
    if (out_load) begin
      median_q   <= med_q;
      empty_q    <= (cnt_q == '0);
      count_q    <= CountBits'(cnt_q);
      ovfl_out_q <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign median_o     = median_q;
  assign empty_res_o  = empty_q;
  assign count_o      = count_q;
  assign overflowed_o = ovfl_out_q;

`ifndef NO_ASSERTIONS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_META) |-> (int'(meta_cnt) <= MAX_PER_BIN))
    else $error("bin count read back above bin capacity");

  a_write_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_we |-> (smp_waddr >= base_q) &&
               ({1'b0, smp_waddr} < ({1'b0, base_q} + (AddrW + 1)'(MAX_PER_BIN))))
    else $error("sample write outside the bin's region");

  a_shift_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (pos_q != '0))
    else $error("shift step at bottom of list");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_RESP))
    else $error("result raised outside response state");
`endif

endmodule

`default_nettype wire
